// ===== src/adm_pkg.sv =====
// Shared types and constants for the adjacency matrix depth-first walk block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package adm_pkg;

   // Default graph size and fixed field widths
   localparam int DEF_MAX_VERTICES = 16;
   localparam int VERTEX_W         = 4;
   localparam int COUNT_W          = 5;
   localparam int KIND_W           = 2;

   // Request codes
   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_WALK = 1'b1
   } req_kind_type;

   // Result codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_VISIT  = 2'd2
   } rsp_kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_ROOT,
      S_SCAN
   } state_type;

   // Sequencer to graph store
   typedef struct packed {
      logic                wr_edge;
      logic [VERTEX_W-1:0] wr_from;
      logic [VERTEX_W-1:0] wr_to;
      logic                clr_marks;
      logic                set_mark;
      logic [VERTEX_W-1:0] row_sel;
      logic [VERTEX_W-1:0] col_sel;
   } graph_ctrl_type;

   // Graph store to sequencer
   typedef struct packed {
      logic hit;    // edge row_sel->col_sel present and col_sel unvisited
      logic seen;   // col_sel already visited
   } graph_stat_type;

endpackage

`default_nettype wire

// ===== src/adm_req_if.sv =====
// Request channel: valid/ready handshake carrying one edge-load or walk item.
// Depends on adm_pkg for field widths.
`default_nettype none

interface adm_req_if
   import adm_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [VERTEX_W-1:0] from_vertex;
   logic [VERTEX_W-1:0] to_vertex;

   modport source (output valid, req_type, from_vertex, to_vertex, input ready);
   modport sink   (input valid, req_type, from_vertex, to_vertex, output ready);
endinterface

`default_nettype wire

// ===== src/adm_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one status or visit item.
// Depends on adm_pkg for field widths.
`default_nettype none

interface adm_rsp_if
   import adm_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [VERTEX_W-1:0] vertex;
   logic                last;

   modport source (output valid, kind, vertex, last, input ready);
   modport sink   (input valid, kind, vertex, last, output ready);
endinterface

`default_nettype wire

// ===== src/adm_graph.sv =====
// Adjacency bit matrix and visited marks, with the single-bit probe unit.
// Depends on adm_pkg for the control and status structs.
`default_nettype none

module adm_graph
   import adm_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire graph_ctrl_type ctrl,
   output graph_stat_type      stat
);
   localparam int VL = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int IW = $clog2(VL);

   logic [VL-1:0] rows_ff [VL];
   logic [VL-1:0] rows_in [VL];
   logic [VL-1:0] marks_ff;
   logic [VL-1:0] marks_in;

   logic [IW-1:0] row_idx;
   logic [IW-1:0] col_idx;

   assign row_idx = ctrl.row_sel[IW-1:0];
   assign col_idx = ctrl.col_sel[IW-1:0];

   // Probe one matrix bit against the visited marks
   always_comb begin
      stat.seen = marks_ff[col_idx];
      stat.hit  = rows_ff[row_idx][col_idx] & ~marks_ff[col_idx];
   end

   // Store an edge
   always_comb begin
      rows_in = rows_ff;
      if (ctrl.wr_edge) begin
         rows_in[ctrl.wr_from[IW-1:0]][ctrl.wr_to[IW-1:0]] = 1'b1;
      end
   end

   // Clear or set visited marks
   always_comb begin
      marks_in = marks_ff;
      if (ctrl.clr_marks) begin
         marks_in = '0;
      end else if (ctrl.set_mark) begin
         marks_in[col_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VL; r++) begin
            rows_ff[r] <= '0;
         end
         marks_ff <= '0;
      end else begin
         rows_ff  <= rows_in;
         marks_ff <= marks_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/adm_seq.sv =====
// Sequencer: request decode, root and neighbour scan, walk stack, result register.
// Depends on adm_pkg and the adm_req_if / adm_rsp_if interfaces.
`default_nettype none

module adm_seq
   import adm_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   localparam int VL = (MAX_VERTICES < 16) ? MAX_VERTICES : 16,
   localparam int CW = $clog2(VL + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [CW-1:0]  used_n,
   adm_req_if.sink             req,
   adm_rsp_if.source           rsp,
   output graph_ctrl_type      ctrl,
   input  wire graph_stat_type stat
);
   localparam int IW = $clog2(VL);
   localparam int NW = VERTEX_W + 1;

   state_type     state_ff, state_in;
   logic [IW-1:0] root_ff, root_in;
   logic [IW-1:0] col_ff, col_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ok_ff, ok_in;
   logic [IW-1:0] stack_ff [VL];
   logic [IW-1:0] stack_in [VL];

   logic                out_valid_ff, out_valid_in;
   rsp_kind_type        out_kind_ff, out_kind_in;
   logic [VERTEX_W-1:0] out_vertex_ff, out_vertex_in;
   logic                out_last_ff, out_last_in;

   logic          slot_free;
   logic          post;
   logic [CW-1:0] n_m1;
   logic [CW-1:0] sp_m1;
   logic [IW-1:0] top_val;
   logic          is_last;
   logic          col_at_end;
   logic [NW-1:0] n_wide;
   logic          edge_ok;

   assign slot_free  = !out_valid_ff || rsp.ready;
   assign n_m1       = used_n - CW'(1);
   assign sp_m1      = sp_ff - CW'(1);
   assign top_val    = stack_ff[sp_m1[IW-1:0]];
   assign is_last    = (count_ff == n_m1);
   assign col_at_end = (CW'(col_ff) == n_m1);
   assign n_wide     = NW'(used_n);
   assign edge_ok    = ({1'b0, req.from_vertex} < n_wide) && ({1'b0, req.to_vertex} < n_wide);

   // Next state, graph control and result posting
   always_comb begin
      state_in      = state_ff;
      root_in       = root_ff;
      col_in        = col_ff;
      sp_in         = sp_ff;
      count_in      = count_ff;
      ok_in         = ok_ff;
      stack_in      = stack_ff;
      post          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_vertex_in = out_vertex_ff;
      out_last_in   = out_last_ff;

      ctrl           = '0;
      ctrl.wr_from   = req.from_vertex;
      ctrl.wr_to     = req.to_vertex;
      ctrl.row_sel   = VERTEX_W'(top_val);
      ctrl.col_sel   = (state_ff == S_ROOT) ? VERTEX_W'(root_ff) : VERTEX_W'(col_ff);

      // Take no item while reset is held
      req.ready = (state_ff == S_IDLE) && !reset;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.req_type == REQ_LOAD) begin
                  ok_in        = edge_ok;
                  ctrl.wr_edge = edge_ok;
                  state_in     = S_LOAD;
               end else begin
                  ctrl.clr_marks = 1'b1;
                  root_in        = '0;
                  col_in         = '0;
                  sp_in          = '0;
                  count_in       = '0;
                  state_in       = S_ROOT;
               end
            end
         end
         S_LOAD: begin
            // Answer the load item once the result register is free
            if (slot_free) begin
               post          = 1'b1;
               out_kind_in   = ok_ff ? KIND_ACCEPT : KIND_REJECT;
               out_vertex_in = '0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ROOT: begin
            // Skip visited roots, open a new walk at the first unvisited one
            if (stat.seen) begin
               root_in = root_ff + IW'(1);
            end else if (slot_free) begin
               post          = 1'b1;
               out_kind_in   = KIND_VISIT;
               out_vertex_in = VERTEX_W'(root_ff);
               out_last_in   = is_last;
               ctrl.set_mark = 1'b1;
               stack_in[0]   = root_ff;
               sp_in         = CW'(1);
               count_in      = count_ff + CW'(1);
               col_in        = '0;
               state_in      = is_last ? S_IDLE : S_SCAN;
            end
         end
         S_SCAN: begin
            // Test one neighbour of the top vertex per cycle, holding on a hit until the result register is free
            if (stat.hit) begin
               if (slot_free) begin
                  post                     = 1'b1;
                  out_kind_in              = KIND_VISIT;
                  out_vertex_in            = VERTEX_W'(col_ff);
                  out_last_in              = is_last;
                  ctrl.set_mark            = 1'b1;
                  stack_in[sp_ff[IW-1:0]]  = col_ff;
                  sp_in                    = sp_ff + CW'(1);
                  count_in                 = count_ff + CW'(1);
                  col_in                   = '0;
                  state_in                 = is_last ? S_IDLE : S_SCAN;
               end
            end else if (col_at_end) begin
               // Row exhausted: pop, and go back to roots when the walk is empty
               col_in = '0;
               sp_in  = sp_m1;
               if (sp_ff == CW'(1)) begin
                  state_in = S_ROOT;
               end
            end else begin
               col_in = col_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hold the result until taken
      if (post) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sp_ff        <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sp_ff        <= sp_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff       <= root_in;
      col_ff        <= col_in;
      ok_ff         <= ok_in;
      stack_ff      <= stack_in;
      out_kind_ff   <= out_kind_in;
      out_vertex_ff <= out_vertex_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.kind   = out_kind_ff;
   assign rsp.vertex = out_vertex_ff;
   assign rsp.last   = out_last_ff;

endmodule

`default_nettype wire

// ===== src/adjacency_matrix_dfs_order_top.sv =====
// Top level of the adjacency matrix depth-first walk block.
// Depends on adm_pkg, adm_req_if, adm_rsp_if, adm_graph and adm_seq.
//
// The block keeps a directed graph of up to 16 vertices as a bit matrix that
// reset clears. A load item (req_type 0) stores the edge from_vertex->to_vertex
// when both are below the vertex count and answers accepted or rejected. A walk
// item (req_type 1) clears the visited marks and returns every vertex in use in
// depth-first order, roots ascending and neighbours ascending, with last set on
// the final vertex. The walk probes one matrix bit per cycle through a single
// shared test unit, except while a visit waits for the result register to free.
// The block takes no new item during a walk. vertex_count is to be written
// through csr_wr_en/csr_wr_data only while idle; the block does not enforce
// this. Values outside 1..16 act as the nearest bound.
`default_nettype none

module adjacency_matrix_dfs_order_top
   import adm_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   adm_req_if.sink                 req_chan,
   adm_rsp_if.source               rsp_chan,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);
   localparam int VL = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int CW = $clog2(VL + 1);
   localparam logic [COUNT_W-1:0] VL_CNT = COUNT_W'(VL);

   logic [COUNT_W-1:0] vertex_count_ff;
   logic [COUNT_W-1:0] vertex_count_in;
   logic [CW-1:0]      used_n;

   graph_ctrl_type ctrl;
   graph_stat_type stat;

   // Latch the vertex count register
   assign vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= COUNT_W'(16);
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // Saturate the count to 1..VL
   always_comb begin
      if (vertex_count_ff == '0) begin
         used_n = CW'(1);
      end else if (vertex_count_ff > VL_CNT) begin
         used_n = CW'(VL);
      end else begin
         used_n = vertex_count_ff[CW-1:0];
      end
   end

   adm_graph #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_graph (
      .clock(clock),
      .reset(reset),
      .ctrl (ctrl),
      .stat (stat)
   );

   adm_seq #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .used_n(used_n),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .ctrl  (ctrl),
      .stat  (stat)
   );

endmodule

`default_nettype wire

// ===== src/adm_checker.sv =====
// Port-level checks for the adjacency matrix depth-first walk block, and the
// bind that attaches them to the top level. Depends on adm_pkg.
`default_nettype none

module adm_checker
   import adm_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [KIND_W-1:0]   rsp_kind,
   input wire logic [VERTEX_W-1:0] rsp_vertex,
   input wire logic                rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_vertex)
         && $stable(rsp_last))
      else $error("stalled result changed");

   // Load answers carry vertex zero and close their item
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_VISIT |-> rsp_vertex == '0 && rsp_last)
      else $error("load status malformed");

   // No undefined result code
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_ACCEPT || rsp_kind == KIND_REJECT
         || rsp_kind == KIND_VISIT)
      else $error("undefined result code");

   // An accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // A walk still in progress takes no new item
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("ready during walk");

endmodule

bind adjacency_matrix_dfs_order_top adm_checker u_adm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.kind),
   .rsp_vertex(rsp_chan.vertex),
   .rsp_last  (rsp_chan.last)
);

`default_nettype wire

// ===== verif/adjacency_matrix_dfs_order_top_tb.sv =====
// Self-checking testbench for adjacency_matrix_dfs_order_top: edge loads and depth-first walks
// are driven on the request channel and every result is checked against a built-in predictor.
// Depends on adm_pkg, adm_req_if, adm_rsp_if and the block's RTL.

module adjacency_matrix_dfs_order_top_tb
   import adm_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 40;
   localparam int LONG_STALL     = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int GRAPH_SIZE     = 16;

   typedef struct packed {
      req_kind_type        op;
      logic [VERTEX_W-1:0] src;
      logic [VERTEX_W-1:0] dst;
   } edge_cmd_type;

   typedef struct packed {
      rsp_kind_type        kind;
      logic [VERTEX_W-1:0] vertex;
      logic                last;
   } dfs_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Driven side of the block
   logic               csr_wr   = 1'b0;
   logic [COUNT_W-1:0] csr_val  = '0;
   logic               snd_valid = 1'b0;
   edge_cmd_type       snd_cmd   = '0;
   logic               rcv_ready = 1'b0;
   logic               long_stall_req = 1'b0;

   // Traffic shaping, percent of cycles spent idle
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int stall_left   = 0;

   // Predictor state
   logic [GRAPH_SIZE-1:0] edge_rows [GRAPH_SIZE];
   logic [COUNT_W-1:0]    vertex_count_cfg = 5'd16;

   edge_cmd_type   edge_cmd_q [$];
   dfs_answer_type answer_q [$];
   dfs_answer_type want_answer;
   dfs_answer_type seen_answer;

   int err_count    = 0;
   int quiet_cycles = 0;
   int n_loads      = 0;
   int n_rejects    = 0;
   int n_walks      = 0;
   int n_visits     = 0;
   int n_settings   = 0;

   adm_req_if req_bus ();
   adm_rsp_if rsp_bus ();

   assign req_bus.valid       = snd_valid;
   assign req_bus.req_type    = snd_cmd.op;
   assign req_bus.from_vertex = snd_cmd.src;
   assign req_bus.to_vertex   = snd_cmd.dst;
   assign rsp_bus.ready       = rcv_ready;

   adjacency_matrix_dfs_order_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr),
      .csr_wr_data (csr_val)
   );

   always #HALF_PERIOD clock = ~clock;

   // Saturate the programmed count to the range the walk actually uses
   function automatic int live_vertices(input logic [COUNT_W-1:0] cnt);
      if (cnt == 0) return 1;
      if (cnt > GRAPH_SIZE) return GRAPH_SIZE;
      return int'(cnt);
   endfunction

   function automatic dfs_answer_type make_answer(input rsp_kind_type kind,
                                                  input logic [VERTEX_W-1:0] vtx,
                                                  input logic lst);
      dfs_answer_type a;
      a.kind   = kind;
      a.vertex = vtx;
      a.last   = lst;
      return a;
   endfunction

   // Apply one accepted item to the graph copy and queue the answers it yields
   task automatic predict_dfs_answers(input edge_cmd_type cmd);
      int n, depth, cnt, nb, top;
      logic [GRAPH_SIZE-1:0] marks;
      logic [VERTEX_W-1:0]   path  [GRAPH_SIZE];
      logic [VERTEX_W-1:0]   order [GRAPH_SIZE];
      n = live_vertices(vertex_count_cfg);
      if (cmd.op == REQ_LOAD) begin
         n_loads++;
         if (cmd.src < n && cmd.dst < n) begin
            edge_rows[cmd.src][cmd.dst] = 1'b1;
            answer_q.push_back(make_answer(KIND_ACCEPT, '0, 1'b1));
         end else begin
            n_rejects++;
            answer_q.push_back(make_answer(KIND_REJECT, '0, 1'b1));
         end
         return;
      end
      n_walks++;
      marks = '0;
      cnt = 0;
      for (int root = 0; root < n; root++) begin
         if (!marks[root]) begin
            marks[root] = 1'b1;
            order[cnt] = 4'(root);
            cnt++;
            path[0] = 4'(root);
            depth = 1;
            while (depth > 0) begin
               top = int'(path[depth-1]);
               // scan down so the lowest open neighbour wins
               nb = n;
               for (int i = n - 1; i >= 0; i--) begin
                  if (edge_rows[top][i] && !marks[i]) nb = i;
               end
               if (nb < n && depth < GRAPH_SIZE && cnt < GRAPH_SIZE) begin
                  marks[nb] = 1'b1;
                  order[cnt] = 4'(nb);
                  cnt++;
                  path[depth] = 4'(nb);
                  depth++;
               end else begin
                  depth--;
               end
            end
         end
      end
      for (int k = 0; k < cnt; k++) begin
         answer_q.push_back(make_answer(KIND_VISIT, order[k], k == cnt - 1));
      end
      n_visits += cnt;
   endtask

   task automatic flag_error(input string what, input dfs_answer_type want,
                             input dfs_answer_type got);
      err_count++;
      if (err_count <= REPORT_LIMIT) begin
         $display("[%0t] %s: expected kind %0d vertex %0d last %0d,",
                  $time, what, want.kind, want.vertex, want.last);
         $display("   got kind %0d vertex %0d last %0d",
                  got.kind, got.vertex, got.last);
      end
   endtask

   // Driver: hold an offered item until accepted, then pick the next or idle
   always @(posedge clock) begin
      if (reset) begin
         snd_valid <= 1'b0;
      end else begin
         if (snd_valid && req_bus.ready) predict_dfs_answers(snd_cmd);
         if (!snd_valid || req_bus.ready) begin
            if (edge_cmd_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               snd_cmd   <= edge_cmd_q.pop_front();
               snd_valid <= 1'b1;
            end else begin
               snd_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result, then throttle ready
   always @(posedge clock) begin
      if (reset) begin
         rcv_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_bus.valid && rcv_ready) begin
            seen_answer.kind   = rsp_kind_type'(rsp_bus.kind);
            seen_answer.vertex = rsp_bus.vertex;
            seen_answer.last   = rsp_bus.last;
            if (answer_q.size() == 0) begin
               flag_error("result with nothing pending", '0, seen_answer);
            end else begin
               want_answer = answer_q.pop_front();
               if (seen_answer.kind !== want_answer.kind ||
                   seen_answer.vertex !== want_answer.vertex ||
                   seen_answer.last !== want_answer.last)
                  flag_error("result mismatch", want_answer, seen_answer);
            end
         end
         if (long_stall_req)
            stall_left <= LONG_STALL;
         else if (stall_left != 0)
            stall_left <= stall_left - 1;
         rcv_ready <= !long_stall_req && stall_left == 0 &&
                      $urandom_range(99) >= rcv_idle_pct;
      end
   end

   // Watchdog: stop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((snd_valid && req_bus.ready) || (rsp_bus.valid && rcv_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_load(input int from_v, input int to_v);
      edge_cmd_type cmd;
      cmd.op  = REQ_LOAD;
      cmd.src = 4'(from_v);
      cmd.dst = 4'(to_v);
      edge_cmd_q.push_back(cmd);
   endtask

   // Vertex fields of a walk are don't-care, so fill them with noise
   task automatic queue_walk();
      edge_cmd_type cmd;
      cmd.op  = REQ_WALK;
      cmd.src = 4'($urandom_range(15));
      cmd.dst = 4'($urandom_range(15));
      edge_cmd_q.push_back(cmd);
   endtask

   task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_wr  <= 1'b1;
      csr_val <= value;
      vertex_count_cfg = value;
      n_settings++;
      @(posedge clock);
      csr_wr <= 1'b0;
   endtask

   // Wait until every item is sent and answered, then let the block go idle
   task automatic wait_drained();
      while (edge_cmd_q.size() != 0 || snd_valid || answer_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly short edge batches closed by a walk, with some stray items mixed in
   task automatic queue_random_items(input int total);
      int made, k, live;
      live = live_vertices(vertex_count_cfg);
      made = 0;
      while (made < total) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(1) == 1)
               queue_walk();
            else
               queue_load($urandom_range(15), $urandom_range(15));
            made++;
         end else begin
            k = $urandom_range(6, 1);
            repeat (k) queue_load($urandom_range(live - 1), $urandom_range(live - 1));
            queue_walk();
            made += k + 1;
         end
      end
   endtask

   task automatic set_idling(input int snd_pct, input int rcv_pct);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
   endtask

   initial begin
      for (int r = 0; r < GRAPH_SIZE; r++) edge_rows[r] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: full count, empty graph, corner edges, self loop, cycle, repeat walk
      set_idling(31, 85);
      write_vertex_count(5'd16);
      queue_walk();
      queue_load(0, 15);
      queue_load(15, 0);
      queue_load(5, 5);
      queue_load(1, 2);
      queue_load(2, 3);
      queue_load(3, 1);
      queue_load(0, 1);
      queue_load(15, 14);
      queue_walk();
      queue_walk();
      wait_drained();

      // Small count: rejects on either side, stale edges ignored by the walk
      write_vertex_count(5'd4);
      queue_load(3, 3);
      queue_load(4, 0);
      queue_load(0, 4);
      queue_load(15, 15);
      queue_walk();
      wait_drained();

      // Zero count acts as one vertex
      write_vertex_count(5'd0);
      queue_load(0, 0);
      queue_load(0, 1);
      queue_walk();
      wait_drained();

      // Oversized count saturates to the full graph
      write_vertex_count(5'd31);
      queue_walk();
      wait_drained();

      // Random, slow receiver
      write_vertex_count(5'd16);
      queue_random_items(120);
      wait_drained();
      write_vertex_count(5'd7);
      queue_random_items(40);
      wait_drained();

      // Random, slow sender
      set_idling(85, 31);
      write_vertex_count(5'd1);
      queue_random_items(20);
      wait_drained();
      write_vertex_count(5'd12);
      queue_random_items(80);
      wait_drained();

      // Full rate with a long receiver hold so the input backs up
      set_idling(0, 0);
      write_vertex_count(5'd17);
      @(posedge clock);
      long_stall_req <= 1'b1;
      @(posedge clock);
      long_stall_req <= 1'b0;
      queue_random_items(60);
      wait_drained();

      // Full rate, sender pauses midway until every answer is back
      write_vertex_count(5'd3);
      queue_random_items(15);
      wait_drained();
      queue_random_items(15);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d edge loads (%0d rejected) and %0d walks with %0d visit reports,",
               n_loads, n_rejects, n_walks, n_visits);
      $display("across %0d vertex-count settings; %0d errors seen.", n_settings, err_count);
      if (err_count == 0 && answer_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
